// ----- rtl/core/hns_pkg.sv -----
// Shared constants, types and action codes for the held note stack.
// No dependencies; imported by hns_slot_mem and held_note_stack_unit.
package hns_pkg;

  // List depth and field widths
  localparam int MaxHeld   = 16;
  localparam int IdxW      = $clog2(MaxHeld);
  localparam int CntW      = $clog2(MaxHeld + 1);
  localparam int CountOutW = 5;
  localparam int ActW      = 2;
  localparam int NoteW     = 7;
  localparam int VelW      = 7;
  localparam int InDataW   = 16;
  localparam int OutDataW  = 24;

  // Action codes on the input stream
  typedef enum logic [ActW-1:0] {
    ACT_ADD     = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_CLEAR   = 2'd2
  } hns_action_e;

  // One stored slot
  typedef struct packed {
    logic [VelW-1:0]  velocity;
    logic [NoteW-1:0] note;
  } hns_slot_t;

  // Request to the slot memory for one cycle
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    hns_slot_t       wdata;
    logic [IdxW-1:0] raddr;
  } hns_mem_req_t;

endpackage

// ----- rtl/core/held_note_stack_unit.sv -----
// Last-note-priority note stack: controller, result register and slot memory.
// Depends on hns_pkg and hns_slot_mem.
//
// Keeps up to MaxHeld held notes, oldest first, in one synchronous memory. An add, a clear
// or an unused action code finishes in the accept cycle and its result beat is presented the
// next cycle. A release walks the list through the memory's single read port, one slot per
// cycle, compacting survivors in place through the write port, before its result beat is
// formed. One item is in flight at a time: a new beat is taken once the previous result beat
// has left the output register. The newest note is kept in a register, so no extra read is
// needed to form a result. No clearing pass is needed after reset.
module held_note_stack_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // [1:0] action, [8:2] note_number, [15:9] velocity
  input  logic [hns_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [0] held_valid, [7:1] held_note, [14:8] held_velocity, [19:15] held_count,
  // [20] overflow, [23:21] zero
  output logic [hns_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready
);
  import hns_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  hns_slot_t           top_q, top_d;
  logic [NoteW-1:0]    target_q, target_d;
  logic [CntW-1:0]     rd_q, rd_d;
  logic [CntW-1:0]     wr_q, wr_d;
  logic                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  hns_mem_req_t        mem_req;
  hns_slot_t           mem_rdata;
  hns_slot_t           in_slot;
  hns_action_e         in_action;
  logic                in_fire;
  logic                emit;
  logic                ovf;
  logic                has_note;

  // Input beat decode
  assign in_action        = hns_action_e'(s_axis_tdata[ActW-1:0]);
  assign in_slot.note     = s_axis_tdata[ActW +: NoteW];
  assign in_slot.velocity = s_axis_tdata[ActW + NoteW +: VelW];
  assign s_axis_tready    = (state_q == ST_IDLE) && !out_valid_q;
  assign in_fire          = s_axis_tvalid && s_axis_tready;

  hns_slot_mem u_slot_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Controller: immediate add/clear, pipelined compaction walk for release
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    top_d         = top_q;
    target_d      = target_q;
    rd_d          = rd_q;
    wr_d          = wr_q;
    pend_d        = 1'b0;
    emit          = 1'b0;
    ovf           = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = count_q[IdxW-1:0];
    mem_req.wdata = in_slot;
    mem_req.raddr = rd_q[IdxW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_ADD: begin
              emit = 1'b1;
              if (count_q < CntW'(MaxHeld)) begin
                mem_req.we = 1'b1;
                count_d    = count_q + CntW'(1);
                top_d      = in_slot;
              end else begin
                ovf = 1'b1;
              end
            end
            ACT_RELEASE: begin
              target_d = in_slot.note;
              rd_d     = '0;
              wr_d     = '0;
              state_d  = ST_WALK;
            end
            ACT_CLEAR: begin
              count_d = '0;
              emit    = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        // Slot read last cycle: keep it unless it matches the released note
        if (pend_q && (mem_rdata.note != target_q)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = wr_q[IdxW-1:0];
          mem_req.wdata = mem_rdata;
          top_d         = mem_rdata;
          wr_d          = wr_q + CntW'(1);
        end
        // Issue next read, or finish once the last read has drained
        if (rd_q < count_q) begin
          rd_d   = rd_q + CntW'(1);
          pend_d = 1'b1;
        end else if (!pend_q) begin
          count_d = wr_q;
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result beat formation
  assign has_note = (count_d != '0);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_data_d  = {3'b000,
                     ovf,
                     CountOutW'(count_d),
                     has_note ? top_d.velocity : VelW'(0),
                     has_note ? top_d.note : NoteW'(0),
                     has_note};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      target_q    <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      top_q       <= top_d;
      target_q    <= target_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxHeld))
    else $error("fill count beyond list depth");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (wr_q <= rd_q))
    else $error("compaction write pointer passed read pointer");

  a_pend_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_WALK))
    else $error("slot read pending outside release walk");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[NoteW + VelW + CountOutW + 1])
      |-> (count_q == CntW'(MaxHeld)))
    else $error("overflow reported with room in list");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[NoteW + VelW + 1 +: CountOutW] != '0)))
    else $error("held_valid disagrees with held_count");

endmodule

// ----- rtl/core/hns_slot_mem.sv -----
// Slot storage: one write port, one read port with registered read data.
// Depends on hns_pkg.
module hns_slot_mem (
  input  logic                 clk_i,
  input  hns_pkg::hns_mem_req_t req_i,
  output hns_pkg::hns_slot_t    rdata_o
);
  import hns_pkg::*;

  hns_slot_t mem_q [MaxHeld];
  hns_slot_t rdata_q;

  // Write and registered read; the controller never uses read data of an entry written in the same cycle
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
